/* rtl/core/hetps_pkg.sv */
// Package for the hashed entry table: field widths, slot payload layout,
// operation and bound codes, and the item and result structs.
// No dependencies.
package hetps_pkg;

    localparam int SLOT_COUNT_DEF = 4096;

    localparam int HASH_W  = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 32;
    localparam int GEN_W   = 6;
    localparam int PAY_W   = 64;

    // Payload layout: move[63:32] score[31:16] depth[15:8] age[7:2] bound[1:0]
    localparam int PAY_BOUND_LSB = 0;
    localparam int PAY_AGE_LSB   = 2;
    localparam int PAY_DEPTH_LSB = 8;
    localparam int PAY_SCORE_LSB = 16;
    localparam int PAY_MOVE_LSB  = 32;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Word index of the register, taken from paddr[2]
    localparam logic REG_SEARCH_GENERATION = 1'b0;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;
    localparam logic [BOUND_W-1:0] BOUND_NONE  = 2'd3;

    typedef struct packed {
        logic                      op;
        logic [HASH_W-1:0]         hash;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
    } item_t;

    typedef struct packed {
        logic                      key_hit;
        logic                      cutoff;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        logic                      written;
    } result_t;

endpackage

/* rtl/core/hetps_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hetps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/hetps_eval.sv */
// Slot evaluation: replacement decision for stores, hit and cutoff for probes.
// Depends on hetps_pkg.
module hetps_eval
    import hetps_pkg::*;
(
    input  item_t              item,
    input  logic [GEN_W-1:0]   generation,
    input  logic [HASH_W-1:0]  slot_key,
    input  logic [PAY_W-1:0]   slot_pay,
    output result_t            res,
    output logic               slot_update,
    output logic [PAY_W-1:0]   new_pay
);

    logic                      key_match;
    logic [DEPTH_W-1:0]        slot_depth;
    logic [GEN_W-1:0]          slot_age;
    logic [BOUND_W-1:0]        slot_bound;
    logic signed [SCORE_W-1:0] slot_score;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic                      keep;
    logic                      cut;
    logic signed [SCORE_W-1:0] chosen;

    assign key_match  = (slot_key == item.hash);
    assign slot_depth = slot_pay[PAY_DEPTH_LSB +: DEPTH_W];
    assign slot_age   = slot_pay[PAY_AGE_LSB +: GEN_W];
    assign slot_bound = slot_pay[PAY_BOUND_LSB +: BOUND_W];
    assign slot_score = slot_pay[PAY_SCORE_LSB +: SCORE_W];
    assign alpha      = item.alpha;
    assign beta       = item.beta;

    // Same position, current age and deeper: keep the slot
    assign keep = key_match && (slot_age == generation) && (slot_depth > item.depth);

    assign new_pay = {item.move, item.score, item.depth, generation, item.bound};

    always_comb
    begin
        cut    = 1'b0;
        chosen = '0;
        if (slot_depth >= item.depth)
        begin
            case (slot_bound)
                BOUND_EXACT:
                begin
                    cut    = 1'b1;
                    chosen = slot_score;
                end
                BOUND_UPPER:
                begin
                    cut    = (slot_score <= alpha);
                    chosen = alpha;
                end
                BOUND_LOWER:
                begin
                    cut    = (slot_score >= beta);
                    chosen = beta;
                end
                default:
                begin
                    cut    = 1'b0;
                    chosen = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        res         = '0;
        slot_update = 1'b0;
        if (item.op == OP_STORE)
        begin
            slot_update = !keep;
            res.written = !keep;
        end
        else if (key_match)
        begin
            res.key_hit = 1'b1;
            res.move    = slot_pay[PAY_MOVE_LSB +: MOVE_W];
            res.cutoff  = cut;
            res.score   = cut ? chosen : '0;
        end
    end

endmodule

/* rtl/core/hashed_entry_table_probe_store.sv */
// Top level of the hashed entry table: control, clearing pass, config port.
// Depends on hetps_pkg, hetps_ram and hetps_eval.
//
// Direct-mapped table of SLOT_COUNT slots (a power of two), selected by the low
// bits of position_hash; keys and payloads sit in two RAMs with a registered
// read. The slot is read in the cycle of the transfer, then evaluated and, for a
// store, written back in the lookup state once the output register is free;
// no new item is taken before then. The result sits in an output register, so
// the next item is taken while a result waits, unless that register is still
// full when the following result is ready. After reset a clearing pass writes
// zero to every slot, one a cycle; in_stall stays high during it, while writes
// to search_generation are taken at any time.
module hashed_entry_table_probe_store
    import hetps_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic [HASH_W-1:0]         position_hash,
    input  logic [DEPTH_W-1:0]        search_depth,
    input  logic signed [SCORE_W-1:0] entry_score,
    input  logic [BOUND_W-1:0]        bound_kind,
    input  logic [MOVE_W-1:0]         best_move_word,
    input  logic signed [SCORE_W-1:0] window_low,
    input  logic signed [SCORE_W-1:0] window_high,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      key_hit,
    output logic                      cutoff,
    output logic signed [SCORE_W-1:0] result_score,
    output logic [MOVE_W-1:0]         result_move,
    output logic                      was_written
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [GEN_W-1:0]   gen_reg, gen_next;
    item_t              item_reg, item_next;
    result_t            result_reg, result_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_xfer;
    logic               out_free;
    logic               finish;
    logic               cfg_wr;

    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [HASH_W-1:0]  key_wr_data;
    logic [PAY_W-1:0]   pay_wr_data;
    logic [HASH_W-1:0]  key_rd_data;
    logic [PAY_W-1:0]   pay_rd_data;

    result_t            eval_res;
    logic               eval_update;
    logic [PAY_W-1:0]   eval_pay;

    // Config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEARCH_GENERATION);
    assign prdata = (paddr[2] == REG_SEARCH_GENERATION)
                    ? {{(APB_DATA_W-GEN_W){1'b0}}, gen_reg} : '0;
    assign gen_next = cfg_wr ? pwdata[GEN_W-1:0] : gen_reg;

    // Handshakes
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = (state_reg == ST_LOOKUP) && out_free;

    always_comb
    begin
        item_next.op    = operation;
        item_next.hash  = position_hash;
        item_next.depth = search_depth;
        item_next.score = entry_score;
        item_next.bound = bound_kind;
        item_next.move  = best_move_word;
        item_next.alpha = window_low;
        item_next.beta  = window_high;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = IDX_W'(clr_idx_reg + 1'b1);
                if (&clr_idx_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            result_next    = eval_res;
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Clearing pass and write-back share the RAM write port
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_reg;
            key_wr_data = '0;
            pay_wr_data = '0;
        end
        else
        begin
            mem_wr_en   = finish && eval_update;
            mem_wr_addr = item_reg.hash[IDX_W-1:0];
            key_wr_data = item_reg.hash;
            pay_wr_data = eval_pay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= item_next;
        end
        result_reg <= result_next;
    end

    hetps_ram #(
        .WIDTH (HASH_W),
        .DEPTH (SLOT_COUNT)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (key_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (position_hash[IDX_W-1:0]),
        .rd_data (key_rd_data)
    );

    hetps_ram #(
        .WIDTH (PAY_W),
        .DEPTH (SLOT_COUNT)
    ) u_pay_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (pay_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (position_hash[IDX_W-1:0]),
        .rd_data (pay_rd_data)
    );

    hetps_eval u_eval (
        .item        (item_reg),
        .generation  (gen_reg),
        .slot_key    (key_rd_data),
        .slot_pay    (pay_rd_data),
        .res         (eval_res),
        .slot_update (eval_update),
        .new_pay     (eval_pay)
    );

    assign out_valid    = out_valid_reg;
    assign key_hit      = result_reg.key_hit;
    assign cutoff       = result_reg.cutoff;
    assign result_score = result_reg.score;
    assign result_move  = result_reg.move;
    assign was_written  = result_reg.written;

    // Slot read is always followed by its evaluation cycle
    a_xfer_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_LOOKUP))
        else $error("transfer not followed by lookup");

    // Outside the clearing pass only stores write the slot memories
    a_wr_store: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && (state_reg != ST_CLEAR)) |-> (item_reg.op == OP_STORE))
        else $error("slot write from a probe");

    // A new result only ever comes out of a lookup
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result without lookup");

    // A store never reports probe fields
    a_store_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.written) |-> (!result_reg.key_hit && !result_reg.cutoff))
        else $error("store result carries probe fields");

endmodule
